// File: rtl/v3cdn_pkg.sv
// ----------------------------------------------------------------------------
// v3cdn_pkg
// Shared widths, codes and bundle types of the 3D vector unit.
// ----------------------------------------------------------------------------
package v3cdn_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CW   = 32;
    localparam int VW   = 2 * CW + 1 - FRAC_BITS;
    localparam int UW   = VW;
    localparam int HW   = (UW + 1) / 2;
    localparam int HIW  = UW - HW;
    localparam int SQW  = 2 * UW;
    localparam int SW   = SQW + 2;
    localparam int RW   = SW / 2;
    localparam int MW   = CW;
    localparam int DW   = CW + FRAC_BITS;
    localparam int OW   = 64;
    localparam int MAGW = 63;

    localparam int IN_DATA_W  = 6 * CW;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = ((4 * OW + MAGW + 7) / 8) * 8;
    localparam int OUT_USER_W = 1;

    localparam int RX_LSB  = 0;
    localparam int RY_LSB  = OW;
    localparam int RZ_LSB  = 2 * OW;
    localparam int MAG_LSB = 3 * OW;
    localparam int DOT_LSB = 3 * OW + MAGW;

    typedef enum logic [1:0] {
        ACT_DIFF  = 2'd0,
        ACT_CROSS = 2'd1,
        ACT_DOT   = 2'd2,
        ACT_NORM  = 2'd3
    } action_t;

    typedef struct packed {
        action_t       action;
        logic [VW-1:0] vx;
        logic [VW-1:0] vy;
        logic [VW-1:0] vz;
        logic [OW-1:0] dot;
    } vec_t;

    typedef struct packed {
        logic [2:0][DW-1:0] q;
        logic [2:0]         neg;
    } quo_t;

endpackage

// File: rtl/v3cdn_front.sv
// ----------------------------------------------------------------------------
// v3cdn_front
// Two stages: component products and differences, then the result vector
// and dot product for the selected action.
// ----------------------------------------------------------------------------
module v3cdn_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  v3cdn_pkg::action_t                   action,
    input  logic signed [v3cdn_pkg::CW-1:0]      ax,
    input  logic signed [v3cdn_pkg::CW-1:0]      ay,
    input  logic signed [v3cdn_pkg::CW-1:0]      az,
    input  logic signed [v3cdn_pkg::CW-1:0]      bx,
    input  logic signed [v3cdn_pkg::CW-1:0]      by_comp,
    input  logic signed [v3cdn_pkg::CW-1:0]      bz,
    output logic                                 out_valid,
    output v3cdn_pkg::vec_t                      out_vec
);

    localparam int PW = 2 * v3cdn_pkg::CW;
    localparam int DFW = v3cdn_pkg::CW + 1;

    logic signed [v3cdn_pkg::CW-1:0] m0a, m0b, m1a, m2b;
    logic signed [PW-1:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DFW-1:0] dx_next, dy_next, dz_next;
    logic signed [DFW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [v3cdn_pkg::CW-1:0] ax_reg, ay_reg, az_reg;
    v3cdn_pkg::action_t act_reg;
    logic valid1_reg;

    logic signed [PW-1:0] f0, f1, f2, f3, f4, f5;
    logic signed [PW-1:0] cx, cy, cz, dsum;
    v3cdn_pkg::vec_t vec_next, vec_reg;
    logic valid2_reg;

    always_comb
    begin
        m0a = (action == v3cdn_pkg::ACT_DOT) ? ax : ay;
        m0b = (action == v3cdn_pkg::ACT_DOT) ? bx : bz;
        m1a = (action == v3cdn_pkg::ACT_DOT) ? ay : az;
        m2b = (action == v3cdn_pkg::ACT_DOT) ? bz : bx;
        p0_next = m0a * m0b;
        p1_next = m1a * by_comp;
        p2_next = az * m2b;
        p3_next = ax * bz;
        p4_next = ax * by_comp;
        p5_next = ay * bx;
        dx_next = DFW'(bx) - DFW'(ax);
        dy_next = DFW'(by_comp) - DFW'(ay);
        dz_next = DFW'(bz) - DFW'(az);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p4_next;
            p5_reg  <= p5_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            ax_reg  <= ax;
            ay_reg  <= ay;
            az_reg  <= az;
            act_reg <= action;
            vec_reg <= vec_next;
        end
    end

    always_comb
    begin
        f0   = p0_reg >>> v3cdn_pkg::FRAC_BITS;
        f1   = p1_reg >>> v3cdn_pkg::FRAC_BITS;
        f2   = p2_reg >>> v3cdn_pkg::FRAC_BITS;
        f3   = p3_reg >>> v3cdn_pkg::FRAC_BITS;
        f4   = p4_reg >>> v3cdn_pkg::FRAC_BITS;
        f5   = p5_reg >>> v3cdn_pkg::FRAC_BITS;
        cx   = f0 - f1;
        cy   = f2 - f3;
        cz   = f4 - f5;
        dsum = f0 + f1 + f2;
        vec_next.action = act_reg;
        vec_next.vx     = '0;
        vec_next.vy     = '0;
        vec_next.vz     = '0;
        vec_next.dot    = '0;
        unique case (act_reg)
            v3cdn_pkg::ACT_DIFF:
            begin
                vec_next.vx = v3cdn_pkg::VW'(dx_reg);
                vec_next.vy = v3cdn_pkg::VW'(dy_reg);
                vec_next.vz = v3cdn_pkg::VW'(dz_reg);
            end
            v3cdn_pkg::ACT_CROSS:
            begin
                vec_next.vx = cx[v3cdn_pkg::VW-1:0];
                vec_next.vy = cy[v3cdn_pkg::VW-1:0];
                vec_next.vz = cz[v3cdn_pkg::VW-1:0];
            end
            v3cdn_pkg::ACT_DOT:
            begin
                vec_next.dot = dsum;
            end
            v3cdn_pkg::ACT_NORM:
            begin
                vec_next.vx = v3cdn_pkg::VW'(ax_reg);
                vec_next.vy = v3cdn_pkg::VW'(ay_reg);
                vec_next.vz = v3cdn_pkg::VW'(az_reg);
            end
            default:
            begin
                vec_next.dot = '0;
            end
        endcase
    end

    assign out_valid = valid2_reg;
    assign out_vec   = vec_reg;

endmodule

// File: rtl/v3cdn_square.sv
// ----------------------------------------------------------------------------
// v3cdn_square
// Three stages: split half-width products, per-component squares, and the
// sum of squares of the result vector.
// ----------------------------------------------------------------------------
module v3cdn_square
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  v3cdn_pkg::vec_t               in_vec,
    output logic                          out_valid,
    output v3cdn_pkg::vec_t               out_vec,
    output logic [v3cdn_pkg::SW-1:0]      sum
);

    localparam int HW  = v3cdn_pkg::HW;
    localparam int HIW = v3cdn_pkg::HIW;
    localparam int UW  = v3cdn_pkg::UW;
    localparam int SQW = v3cdn_pkg::SQW;
    localparam int SW  = v3cdn_pkg::SW;

    logic [v3cdn_pkg::VW-1:0] vin [3];
    logic [UW-1:0]            ux  [3];
    logic [HIW-1:0]           xh  [3];
    logic [HW-1:0]            xl  [3];
    logic [2*HIW-1:0]         hh_next [3];
    logic [2*HIW-1:0]         hh_reg  [3];
    logic [HIW+HW-1:0]        hl_next [3];
    logic [HIW+HW-1:0]        hl_reg  [3];
    logic [2*HW-1:0]          ll_next [3];
    logic [2*HW-1:0]          ll_reg  [3];
    logic [SQW-1:0]           sq_next [3];
    logic [SQW-1:0]           sq_reg  [3];
    logic [SW-1:0]            sum_next, sum_reg;

    v3cdn_pkg::vec_t va_reg, vb_reg, vc_reg;
    logic va_valid_reg, vb_valid_reg, vc_valid_reg;

    assign vin[0] = in_vec.vx;
    assign vin[1] = in_vec.vy;
    assign vin[2] = in_vec.vz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ux[i] = vin[i][v3cdn_pkg::VW-1] ? (~vin[i] + UW'(1)) : vin[i];
            xh[i] = ux[i][UW-1:HW];
            xl[i] = ux[i][HW-1:0];
            hh_next[i] = {{HIW{1'b0}}, xh[i]} * {{HIW{1'b0}}, xh[i]};
            hl_next[i] = {{HW{1'b0}}, xh[i]} * {{HIW{1'b0}}, xl[i]};
            ll_next[i] = {{HW{1'b0}}, xl[i]} * {{HW{1'b0}}, xl[i]};
            sq_next[i] = (SQW'(hh_reg[i]) << (2 * HW))
                       + (SQW'(hl_reg[i]) << (HW + 1))
                       + SQW'(ll_reg[i]);
        end
        sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_valid_reg <= 1'b0;
            vb_valid_reg <= 1'b0;
            vc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_valid_reg <= in_valid;
            vb_valid_reg <= va_valid_reg;
            vc_valid_reg <= vb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= hh_next[i];
                hl_reg[i] <= hl_next[i];
                ll_reg[i] <= ll_next[i];
                sq_reg[i] <= sq_next[i];
            end
            sum_reg <= sum_next;
            va_reg  <= in_vec;
            vb_reg  <= va_reg;
            vc_reg  <= vb_reg;
        end
    end

    assign out_valid = vc_valid_reg;
    assign out_vec   = vc_reg;
    assign sum       = sum_reg;

endmodule

// File: rtl/v3cdn_sqrt.sv
// ----------------------------------------------------------------------------
// v3cdn_sqrt
// Digit-by-digit integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module v3cdn_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  v3cdn_pkg::vec_t               in_vec,
    input  logic [v3cdn_pkg::SW-1:0]      sum,
    output logic                          out_valid,
    output v3cdn_pkg::vec_t               out_vec,
    output logic [v3cdn_pkg::RW-1:0]      root
);

    localparam int SW = v3cdn_pkg::SW;
    localparam int RW = v3cdn_pkg::RW;

    logic [SW-1:0]   rem_reg   [RW-1];
    logic [RW-1:0]   root_reg  [RW];
    v3cdn_pkg::vec_t vec_reg   [RW];
    logic            valid_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_step
        localparam int B = RW - 1 - k;

        logic [SW-1:0]   rem_in, trial, rem_next;
        logic [RW-1:0]   root_in, root_next;
        v3cdn_pkg::vec_t vec_in;
        logic            valid_in;

        if (k == 0)
        begin : g_first
            assign rem_in   = sum;
            assign root_in  = '0;
            assign vec_in   = in_vec;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign vec_in   = vec_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        always_comb
        begin
            trial = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (RW'(1) << B);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= root_next;
                vec_reg[k]  <= vec_in;
            end
        end

        if (k < RW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_vec   = vec_reg[RW-1];
    assign root      = root_reg[RW-1];

endmodule

// File: rtl/v3cdn_div.sv
// ----------------------------------------------------------------------------
// v3cdn_div
// Three-lane restoring divider for normalize, one quotient bit per stage;
// the dividend shifts out as the quotient shifts in.
// ----------------------------------------------------------------------------
module v3cdn_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  v3cdn_pkg::vec_t               in_vec,
    input  logic [v3cdn_pkg::RW-1:0]      in_root,
    output logic                          out_valid,
    output v3cdn_pkg::vec_t               out_vec,
    output logic [v3cdn_pkg::RW-1:0]      out_root,
    output v3cdn_pkg::quo_t               out_quo
);

    localparam int DW = v3cdn_pkg::DW;
    localparam int MW = v3cdn_pkg::MW;
    localparam int VW = v3cdn_pkg::VW;
    localparam int CW = v3cdn_pkg::CW;

    logic [VW-1:0]            vin [3];
    logic [VW-1:0]            uin [3];
    logic [2:0][DW-1:0]       dq0;
    logic [2:0]               neg0;

    logic [2:0][DW-1:0]       dq_reg    [DW];
    logic [2:0][MW-1:0]       rem_reg   [DW-1];
    logic [MW-1:0]            m_reg     [DW-1];
    logic [2:0]               neg_reg   [DW];
    logic [v3cdn_pkg::RW-1:0] root_reg  [DW];
    v3cdn_pkg::vec_t          vec_reg   [DW];
    logic                     valid_reg [DW];

    assign vin[0] = in_vec.vx;
    assign vin[1] = in_vec.vy;
    assign vin[2] = in_vec.vz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            uin[i]  = vin[i][VW-1] ? (~vin[i] + VW'(1)) : vin[i];
            dq0[i]  = {uin[i][CW-1:0], {v3cdn_pkg::FRAC_BITS{1'b0}}};
            neg0[i] = vin[i][VW-1];
        end
    end

    for (genvar j = 0; j < DW; j++)
    begin : g_step
        logic [2:0][DW-1:0] dq_in, dq_next;
        logic [2:0][MW-1:0] rem_in, rem_next;
        logic [MW-1:0]      m_in;
        logic [2:0]         neg_in;
        logic [v3cdn_pkg::RW-1:0] root_in;
        v3cdn_pkg::vec_t    vec_in;
        logic               valid_in;
        logic [MW:0]        r2   [3];
        logic [MW:0]        diff [3];

        if (j == 0)
        begin : g_first
            assign dq_in    = dq0;
            assign rem_in   = '0;
            assign m_in     = in_root[MW-1:0];
            assign neg_in   = neg0;
            assign root_in  = in_root;
            assign vec_in   = in_vec;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign dq_in    = dq_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign m_in     = m_reg[j-1];
            assign neg_in   = neg_reg[j-1];
            assign root_in  = root_reg[j-1];
            assign vec_in   = vec_reg[j-1];
            assign valid_in = valid_reg[j-1];
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                r2[i]   = {rem_in[i], dq_in[i][DW-1]};
                diff[i] = r2[i] - {1'b0, m_in};
                if (r2[i] >= {1'b0, m_in})
                begin
                    rem_next[i] = diff[i][MW-1:0];
                    dq_next[i]  = {dq_in[i][DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = r2[i][MW-1:0];
                    dq_next[i]  = {dq_in[i][DW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[j]   <= dq_next;
                neg_reg[j]  <= neg_in;
                root_reg[j] <= root_in;
                vec_reg[j]  <= vec_in;
            end
        end

        if (j < DW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    m_reg[j]   <= m_in;
                end
            end
        end
    end

    assign out_valid   = valid_reg[DW-1];
    assign out_vec     = vec_reg[DW-1];
    assign out_root    = root_reg[DW-1];
    assign out_quo.q   = dq_reg[DW-1];
    assign out_quo.neg = neg_reg[DW-1];

endmodule

// File: rtl/vector3_cross_dot_normalize_top.sv
// ----------------------------------------------------------------------------
// vector3_cross_dot_normalize_top
// Stateless 3D vector unit: difference, cross, dot and normalize on Q15.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis: tuser selects the action (difference,
//   cross product, dot product, normalize A) and tdata carries A and B.
//   One result word per input word leaves on m_axis, in input order.
//   From acceptance to m_axis_tvalid a word passes through two front
//   stages, three sum-of-squares stages, one square root stage per root
//   bit, one divider stage per quotient bit, and the output register.
//   Throughput is one word per cycle while m_axis takes each word; a new
//   word can enter every cycle while earlier ones are in flight.
//   All stages advance together: when the output register holds a word
//   that is not taken, the whole pipeline holds and s_axis_tready drops,
//   and nothing is lost or repeated.
//   Reset clears every valid bit; the block comes out of reset empty and
//   ready. Normalizing the zero vector returns zeros with tuser set.
// ----------------------------------------------------------------------------
module vector3_cross_dot_normalize_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // ax, ay, az, bx, by_comp, bz
    input  logic [v3cdn_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // action
    input  logic [v3cdn_pkg::IN_USER_W-1:0]        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // rx, ry, rz, magnitude, dot_value, zero pad
    output logic [v3cdn_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // zero_length
    output logic [v3cdn_pkg::OUT_USER_W-1:0]       m_axis_tuser
);

    localparam int CW = v3cdn_pkg::CW;
    localparam int OW = v3cdn_pkg::OW;
    localparam int VW = v3cdn_pkg::VW;

    logic en;

    logic                     fr_valid, sq_valid, rt_valid, dv_valid;
    v3cdn_pkg::vec_t          fr_vec, sq_vec, rt_vec, dv_vec;
    logic [v3cdn_pkg::SW-1:0] sq_sum;
    logic [v3cdn_pkg::RW-1:0] rt_root, dv_root;
    v3cdn_pkg::quo_t          dv_quo;

    logic [VW-1:0]            lane_v [3];
    logic [OW-1:0]            lane_r [3];
    logic                     norm, zero;
    logic [v3cdn_pkg::MAGW-1:0] mag;
    logic [v3cdn_pkg::OUT_DATA_W-1:0] data_next, data_reg;
    logic                     zero_reg, valid_reg;

    assign en            = !valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    v3cdn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .action    (v3cdn_pkg::action_t'(s_axis_tuser)),
        .ax        (s_axis_tdata[CW-1:0]),
        .ay        (s_axis_tdata[2*CW-1:CW]),
        .az        (s_axis_tdata[3*CW-1:2*CW]),
        .bx        (s_axis_tdata[4*CW-1:3*CW]),
        .by_comp   (s_axis_tdata[5*CW-1:4*CW]),
        .bz        (s_axis_tdata[6*CW-1:5*CW]),
        .out_valid (fr_valid),
        .out_vec   (fr_vec)
    );

    v3cdn_square u_square
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_vec    (fr_vec),
        .out_valid (sq_valid),
        .out_vec   (sq_vec),
        .sum       (sq_sum)
    );

    v3cdn_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_vec    (sq_vec),
        .sum       (sq_sum),
        .out_valid (rt_valid),
        .out_vec   (rt_vec),
        .root      (rt_root)
    );

    v3cdn_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .in_vec    (rt_vec),
        .in_root   (rt_root),
        .out_valid (dv_valid),
        .out_vec   (dv_vec),
        .out_root  (dv_root),
        .out_quo   (dv_quo)
    );

    assign lane_v[0] = dv_vec.vx;
    assign lane_v[1] = dv_vec.vy;
    assign lane_v[2] = dv_vec.vz;

    always_comb
    begin
        norm = (dv_vec.action == v3cdn_pkg::ACT_NORM);
        zero = norm && (dv_root == '0);
        for (int i = 0; i < 3; i++)
        begin
            if (zero)
            begin
                lane_r[i] = '0;
            end
            else if (norm)
            begin
                lane_r[i] = dv_quo.neg[i] ? (~OW'(dv_quo.q[i]) + OW'(1))
                                          : OW'(dv_quo.q[i]);
            end
            else
            begin
                lane_r[i] = {{(OW - VW){lane_v[i][VW-1]}}, lane_v[i]};
            end
        end
        if (zero)
        begin
            mag = '0;
        end
        else if (norm)
        begin
            mag = v3cdn_pkg::MAGW'(1) << v3cdn_pkg::FRAC_BITS;
        end
        else
        begin
            mag = v3cdn_pkg::MAGW'(dv_root);
        end
        data_next = '0;
        data_next[v3cdn_pkg::RX_LSB +: OW]               = lane_r[0];
        data_next[v3cdn_pkg::RY_LSB +: OW]               = lane_r[1];
        data_next[v3cdn_pkg::RZ_LSB +: OW]               = lane_r[2];
        data_next[v3cdn_pkg::MAG_LSB +: v3cdn_pkg::MAGW] = mag;
        data_next[v3cdn_pkg::DOT_LSB +: OW]              = dv_vec.dot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            zero_reg <= zero;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = zero_reg;

endmodule

// File: rtl/v3cdn_checker.sv
// ----------------------------------------------------------------------------
// v3cdn_checker
// Port-level checks of the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module v3cdn_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    input  logic [v3cdn_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input  logic [v3cdn_pkg::IN_USER_W-1:0]        s_axis_tuser,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic [v3cdn_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  logic [v3cdn_pkg::OUT_USER_W-1:0]       m_axis_tuser
);

    localparam int DL = v3cdn_pkg::DOT_LSB;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input held off without an output stall");

    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("zero-length word carries nonzero data");

    a_dot_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[DL +: v3cdn_pkg::OW] != '0) |->
            m_axis_tdata[DL-1:0] == '0 && !m_axis_tuser[0])
        else $error("dot word carries vector data");

endmodule

bind vector3_cross_dot_normalize_top v3cdn_checker u_checker (.*);
